@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the lod shell cull RTL.
// Both expect clk to be visible where they are used; LSC_ASSERT also needs rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define LSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define LSC_ASSERT_NR(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hw/rtl/lsc_pkg.sv @@
package lsc_pkg;

    localparam int LEVELS     = 8;
    localparam int LEVEL_W    = 3;
    localparam int POS_W      = 32;
    localparam int MAG_W      = 16;
    localparam int COL_W      = 8;
    localparam int MAXP_W     = 24;
    localparam int RAD_W      = 32;
    localparam int SQ_W       = 64;
    localparam int SUM_W      = 66;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // levels at or above this one skip the distance test
    localparam logic [LEVEL_W-1:0] KEEP_LEVEL = LEVEL_W'(LEVELS - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAMERA_X     = 3'd0,
        REG_CAMERA_Y     = 3'd1,
        REG_CAMERA_Z     = 3'd2,
        REG_MAX_POINTS   = 3'd3,
        REG_RADII_LO     = 3'd4,
        REG_RADII_MID    = 3'd5,
        REG_RADII_HI     = 3'd6,
        REG_RADIUS_TOP   = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic                    first_of_scan;
        logic [LEVEL_W-1:0]      detail_level;
        logic signed [POS_W-1:0] star_x;
        logic signed [POS_W-1:0] star_y;
        logic signed [POS_W-1:0] star_z;
        logic signed [MAG_W-1:0] star_mag;
        logic [COL_W-1:0]        color_r;
        logic [COL_W-1:0]        color_g;
        logic [COL_W-1:0]        color_b;
    } star_in_t;

    typedef struct packed {
        logic signed [POS_W-1:0] out_x;
        logic signed [POS_W-1:0] out_y;
        logic signed [POS_W-1:0] out_z;
        logic signed [MAG_W-1:0] out_mag;
        logic [COL_W-1:0]        out_r;
        logic [COL_W-1:0]        out_g;
        logic [COL_W-1:0]        out_b;
    } star_out_t;

    typedef struct packed {
        logic signed [POS_W-1:0] camera_x;
        logic signed [POS_W-1:0] camera_y;
        logic signed [POS_W-1:0] camera_z;
        logic [MAXP_W-1:0]       max_points;
        logic [CFG_DATA_W-1:0]   radii_lo;
        logic [CFG_DATA_W-1:0]   radii_mid;
        logic [CFG_DATA_W-1:0]   radii_hi;
        logic [RAD_W-1:0]        radius_top;
    } lsc_cfg_t;

    typedef struct packed {
        logic             first_of_scan;
        logic             keep_all;
        logic [POS_W-1:0] dx;
        logic [POS_W-1:0] dy;
        logic [POS_W-1:0] dz;
        logic [RAD_W-1:0] radius;
        star_out_t        payload;
    } diff_stage_t;

    typedef struct packed {
        logic            first_of_scan;
        logic            keep_all;
        logic [SQ_W-1:0] sq_x;
        logic [SQ_W-1:0] sq_y;
        logic [SQ_W-1:0] sq_z;
        logic [SQ_W-1:0] r2;
        star_out_t       payload;
    } sq_stage_t;

    // |a - b| of two signed words; always fits in POS_W bits
    function automatic logic [POS_W-1:0] abs_diff(logic [POS_W-1:0] a, logic [POS_W-1:0] b);
        logic [POS_W:0] d;
        logic [POS_W:0] m;
        d = {a[POS_W-1], a} - {b[POS_W-1], b};
        m = d[POS_W] ? (~d + 1'b1) : d;
        return m[POS_W-1:0];
    endfunction

    function automatic logic [RAD_W-1:0] radius_of(logic [LEVEL_W-1:0] level, lsc_cfg_t c);
        logic [RAD_W-1:0] r;
        case (level)
            3'd0:    r = c.radii_lo[RAD_W-1:0];
            3'd1:    r = c.radii_lo[2*RAD_W-1:RAD_W];
            3'd2:    r = c.radii_mid[RAD_W-1:0];
            3'd3:    r = c.radii_mid[2*RAD_W-1:RAD_W];
            3'd4:    r = c.radii_hi[RAD_W-1:0];
            3'd5:    r = c.radii_hi[2*RAD_W-1:RAD_W];
            default: r = c.radius_top;
        endcase
        return r;
    endfunction

endpackage

@@ hw/rtl/lod_shell_point_cull.sv @@
// Pipeline: a star word accepted into the input register passes through axis deltas,
// squares, sum/compare and budget into the output register, which drives point word valid.
// Throughput: one star word per cycle; the whole pipe holds while the output word waits.
// Culled stars leave a one-cycle bubble and produce no output word.
// Reset (rst_n low, asynchronous) clears all valid bits, the budget count and the
// configuration registers.
module lod_shell_point_cull
    import lsc_pkg::*;
#(
    parameter int COUNT_BITS = 24
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  star_valid,
    output logic                  star_ready,
    input  star_in_t              star_word,
    output logic                  point_valid,
    input  logic                  point_ready,
    output star_out_t             point_word,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    lsc_cfg_t  cfg;
    logic      adv;
    logic      s0_valid_reg;
    star_in_t  s0_reg;
    logic      sq_valid;
    sq_stage_t sq;

    assign star_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg <= star_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_reg <= star_word;
        end
    end

    lsc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lsc_dist u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (s0_valid_reg),
        .in_word  (s0_reg),
        .cfg      (cfg),
        .sq_valid (sq_valid),
        .sq       (sq)
    );

    lsc_gate #(
        .COUNT_BITS (COUNT_BITS)
    ) u_gate (
        .clk         (clk),
        .rst_n       (rst_n),
        .sq_valid    (sq_valid),
        .sq          (sq),
        .cfg_max     (cfg.max_points),
        .point_ready (point_ready),
        .point_valid (point_valid),
        .point_word  (point_word),
        .adv         (adv)
    );

endmodule

@@ hw/rtl/lsc_cfg.sv @@
module lsc_cfg
    import lsc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output lsc_cfg_t              cfg
);

    lsc_cfg_t cfg_reg;
    lsc_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CAMERA_X:   cfg_next.camera_x   = cfg_data[POS_W-1:0];
                REG_CAMERA_Y:   cfg_next.camera_y   = cfg_data[POS_W-1:0];
                REG_CAMERA_Z:   cfg_next.camera_z   = cfg_data[POS_W-1:0];
                REG_MAX_POINTS: cfg_next.max_points = cfg_data[MAXP_W-1:0];
                REG_RADII_LO:   cfg_next.radii_lo   = cfg_data;
                REG_RADII_MID:  cfg_next.radii_mid  = cfg_data;
                REG_RADII_HI:   cfg_next.radii_hi   = cfg_data;
                REG_RADIUS_TOP: cfg_next.radius_top = cfg_data[RAD_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ hw/rtl/lsc_dist.sv @@
`include "assert_macros.svh"

module lsc_dist
    import lsc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      adv,
    input  logic      in_valid,
    input  star_in_t  in_word,
    input  lsc_cfg_t  cfg,
    output logic      sq_valid,
    output sq_stage_t sq
);

    diff_stage_t s1_reg;
    diff_stage_t s1_next;
    logic        s1_valid_reg;
    sq_stage_t   s2_reg;
    sq_stage_t   s2_next;
    logic        s2_valid_reg;

    // stage 1: per-axis magnitudes and shell radius
    always_comb
    begin
        s1_next.first_of_scan   = in_word.first_of_scan;
        s1_next.keep_all        = (in_word.detail_level >= KEEP_LEVEL);
        s1_next.dx              = abs_diff(in_word.star_x, cfg.camera_x);
        s1_next.dy              = abs_diff(in_word.star_y, cfg.camera_y);
        s1_next.dz              = abs_diff(in_word.star_z, cfg.camera_z);
        s1_next.radius          = radius_of(in_word.detail_level, cfg);
        s1_next.payload.out_x   = in_word.star_x;
        s1_next.payload.out_y   = in_word.star_y;
        s1_next.payload.out_z   = in_word.star_z;
        s1_next.payload.out_mag = in_word.star_mag;
        s1_next.payload.out_r   = in_word.color_r;
        s1_next.payload.out_g   = in_word.color_g;
        s1_next.payload.out_b   = in_word.color_b;
    end

    // stage 2: four squares, exact in 64 bits
    always_comb
    begin
        s2_next.first_of_scan = s1_reg.first_of_scan;
        s2_next.keep_all      = s1_reg.keep_all;
        s2_next.sq_x          = SQ_W'(s1_reg.dx) * SQ_W'(s1_reg.dx);
        s2_next.sq_y          = SQ_W'(s1_reg.dy) * SQ_W'(s1_reg.dy);
        s2_next.sq_z          = SQ_W'(s1_reg.dz) * SQ_W'(s1_reg.dz);
        s2_next.r2            = SQ_W'(s1_reg.radius) * SQ_W'(s1_reg.radius);
        s2_next.payload       = s1_reg.payload;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
        end
    end

    assign sq_valid = s2_valid_reg;
    assign sq       = s2_reg;

    `LSC_ASSERT(a_s2_follows_s1, (adv && s1_valid_reg) |=> s2_valid_reg, "stage 2 lost a word")

endmodule

@@ hw/rtl/lsc_gate.sv @@
`include "assert_macros.svh"

module lsc_gate
    import lsc_pkg::*;
#(
    parameter int COUNT_BITS = 24
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sq_valid,
    input  sq_stage_t         sq,
    input  logic [MAXP_W-1:0] cfg_max,
    input  logic              point_ready,
    output logic              point_valid,
    output star_out_t         point_word,
    output logic              adv
);

    localparam int CMP_W = (COUNT_BITS > MAXP_W) ? COUNT_BITS : MAXP_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    star_out_t             out_reg;

    logic [SUM_W-1:0]      dist2;
    logic                  keep;
    logic [COUNT_BITS-1:0] eff_count;
    logic                  budget_ok;
    logic                  pass;

    assign adv = !out_valid_reg || point_ready;

    always_comb
    begin
        dist2     = SUM_W'(sq.sq_x) + SUM_W'(sq.sq_y) + SUM_W'(sq.sq_z);
        keep      = sq.keep_all || (dist2 <= SUM_W'(sq.r2));
        // a new scan restarts the budget before this star is judged
        eff_count = sq.first_of_scan ? '0 : count_reg;
        budget_ok = CMP_W'(eff_count) < CMP_W'(cfg_max);
        pass      = keep && budget_ok;

        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        if (adv)
        begin
            out_valid_next = sq_valid && pass;
            if (sq_valid)
            begin
                if (pass && (eff_count != CNT_MAX))
                begin
                    count_next = eff_count + 1'b1;
                end
                else
                begin
                    count_next = eff_count;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= sq.payload;
        end
    end

    assign point_valid = out_valid_reg;
    assign point_word  = out_reg;

    `LSC_ASSERT(a_count_step, (adv && sq_valid && pass && !sq.first_of_scan && (count_reg != CNT_MAX)) |=> (count_reg == $past(count_reg) + 1'b1), "budget count did not step")
    `LSC_ASSERT(a_scan_clear, (adv && sq_valid && sq.first_of_scan && !pass) |=> (count_reg == '0), "scan start did not clear count")
    `LSC_ASSERT(a_budget_block, (adv && sq_valid && !budget_ok) |=> !out_valid_reg, "word emitted over budget")
    `LSC_ASSERT_NR(a_reset_idle, !rst_n |=> (!out_valid_reg && (count_reg == '0)), "state not clear in reset")

endmodule
